// ===== src/cfpg_pkg.sv =====
`default_nettype none

package cfpg_pkg;

  localparam int unsigned XW = 5;
  localparam int unsigned YW = 4;
  localparam int unsigned HW = 5;
  localparam int unsigned MW = 6;
  localparam int unsigned PW = 8;

  typedef logic [XW-1:0] px_x_t;
  typedef logic [YW-1:0] px_y_t;
  typedef logic [HW-1:0] hours_t;
  typedef logic [MW-1:0] minutes_t;
  typedef logic [PW-1:0] pix_t;
  typedef logic [3:0]    digit_t;
  typedef logic [3:0]    glyph_row_t;

  typedef struct packed {
    px_x_t    pixel_x;
    px_y_t    pixel_y;
    hours_t   hours;
    minutes_t minutes;
    logic     colon_on;
    logic     wifi_up;
    logic     bt_up;
    logic     zigbee_up;
  } in_item_t;

  localparam pix_t LIT_FULL = 8'hFF;
  localparam pix_t LIT_DOT  = 8'h80;
  localparam pix_t LIT_OFF  = 8'h00;

  localparam px_y_t GLYPH_TOP    = 4'd3;
  localparam px_y_t GLYPH_BOTTOM = 4'd12;
  localparam px_x_t COLON_X      = 5'd11;
  localparam px_y_t STATUS_Y     = 4'd15;
  localparam px_x_t WIFI_X       = 5'd1;
  localparam px_x_t BT_X         = 5'd5;
  localparam px_x_t ZIGBEE_X     = 5'd9;

  localparam px_x_t DIGIT_LEFT [4] = '{5'd1, 5'd6, 5'd14, 5'd19};

  // glyph rows, msb is the leftmost column
  localparam glyph_row_t GLYPH_ROM [10][10] = '{
    '{4'hE, 4'h9, 4'h9, 4'h9, 4'h9, 4'h9, 4'h9, 4'h9, 4'h9, 4'hE},
    '{4'h2, 4'h6, 4'hA, 4'h2, 4'h2, 4'h2, 4'h2, 4'h2, 4'h2, 4'h7},
    '{4'hE, 4'h9, 4'h1, 4'h1, 4'h2, 4'h4, 4'h8, 4'h8, 4'h9, 4'hF},
    '{4'hE, 4'h9, 4'h1, 4'h1, 4'h6, 4'h1, 4'h1, 4'h1, 4'h9, 4'hE},
    '{4'h9, 4'h9, 4'h9, 4'h9, 4'hF, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1},
    '{4'hF, 4'h8, 4'h8, 4'h8, 4'hE, 4'h1, 4'h1, 4'h1, 4'h9, 4'hE},
    '{4'h6, 4'h8, 4'h8, 4'h8, 4'hE, 4'h9, 4'h9, 4'h9, 4'h9, 4'hE},
    '{4'hF, 4'h1, 4'h1, 4'h2, 4'h2, 4'h4, 4'h4, 4'h8, 4'h8, 4'h8},
    '{4'hE, 4'h9, 4'h9, 4'h9, 4'h6, 4'h9, 4'h9, 4'h9, 4'h9, 4'hE},
    '{4'hE, 4'h9, 4'h9, 4'h9, 4'h7, 4'h1, 4'h1, 4'h1, 4'h1, 4'h6}
  };

endpackage

`default_nettype wire

// ===== src/cfpg_if.sv =====
`default_nettype none

interface cfpg_in_if
  import cfpg_pkg::*;
();
  logic     valid;
  logic     ready;
  px_x_t    pixel_x;
  px_y_t    pixel_y;
  hours_t   hours;
  minutes_t minutes;
  logic     colon_on;
  logic     wifi_up;
  logic     bt_up;
  logic     zigbee_up;

  modport source (
    output valid, pixel_x, pixel_y, hours, minutes, colon_on, wifi_up, bt_up, zigbee_up,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, hours, minutes, colon_on, wifi_up, bt_up, zigbee_up,
    output ready
  );
endinterface

interface cfpg_out_if
  import cfpg_pkg::*;
();
  logic valid;
  logic ready;
  pix_t pixel_value;

  modport source (output valid, pixel_value, input ready);
  modport sink (input valid, pixel_value, output ready);
endinterface

`default_nettype wire

// ===== src/cfpg_render.sv =====
`default_nettype none

module cfpg_render
  import cfpg_pkg::*;
(
  input  wire in_item_t item,
  output pix_t          pixel_value
);

  logic [HW+4:0]  h_prod;
  logic [MW+7:0]  m_prod;
  digit_t         digits [4];
  px_y_t          row;
  logic           in_rows;
  logic           digit_lit;
  logic           colon_lit;
  logic           dot_lit;
  px_x_t          col;
  glyph_row_t     grow;

  // divide by ten through reciprocal multiply, exact over the field ranges
  always_comb begin
    h_prod    = {5'd0, item.hours} * 10'd13;
    m_prod    = {8'd0, item.minutes} * 14'd205;
    digits[0] = 4'(h_prod >> 7);
    digits[1] = 4'(item.hours - 5'(digits[0] * 4'd10));
    digits[2] = 4'(m_prod >> 11);
    digits[3] = 4'(item.minutes - 6'(digits[2] * 4'd10));
  end

  always_comb begin
    in_rows   = (item.pixel_y >= GLYPH_TOP) && (item.pixel_y <= GLYPH_BOTTOM);
    row       = item.pixel_y - GLYPH_TOP;
    digit_lit = 1'b0;
    for (int i = 0; i < 4; i++) begin
      col  = item.pixel_x - DIGIT_LEFT[i];
      grow = GLYPH_ROM[digits[i]][row];
      if (in_rows && (item.pixel_x >= DIGIT_LEFT[i]) && (col < 5'd4) &&
          grow[2'd3 - col[1:0]]) begin
        digit_lit = 1'b1;
      end
    end
  end

  always_comb begin
    colon_lit = item.colon_on && (item.pixel_x == COLON_X) &&
                ((item.pixel_y == 4'd6) || (item.pixel_y == 4'd7) ||
                 (item.pixel_y == 4'd9) || (item.pixel_y == 4'd10));
    dot_lit   = (item.pixel_y == STATUS_Y) &&
                (((item.pixel_x == WIFI_X) && item.wifi_up) ||
                 ((item.pixel_x == BT_X) && item.bt_up) ||
                 ((item.pixel_x == ZIGBEE_X) && item.zigbee_up));
  end

  always_comb begin
    if (dot_lit) begin
      pixel_value = LIT_DOT;
    end else if (digit_lit || colon_lit) begin
      pixel_value = LIT_FULL;
    end else begin
      pixel_value = LIT_OFF;
    end
  end

endmodule

`default_nettype wire

// ===== src/clock_face_pixel_generator_core.sv =====
// Clock face pixel generator for a 25 x 16 LED panel.
// in_chan: one pixel request per transfer (pixel_x, pixel_y, hours, minutes,
//   colon_on and the three link-status flags). out_chan: one pixel_value per
//   request, in request order.
// Pipeline: a request register feeds the glyph and region decode, which
//   feeds the result register. Throughput: one pixel per cycle while the
//   receiver is ready.
// Digits are drawn at columns 1, 6, 14 and 19 on rows 3 to 12 at 255, the
//   colon at column 11 at 255 when colon_on is set, status dots on row 15 at
//   128. Everything else reads 0.
// Reset empties both pipeline registers; in_chan.ready is high once reset
//   has taken effect and stays high after release until a stall fills both.
// When out_chan.ready is low the result register holds its pixel; the
//   request register still takes one more request, after which in_chan.ready
//   falls until the receiver takes the waiting result.
`default_nettype none

module clock_face_pixel_generator_core
  import cfpg_pkg::*;
(
  input  wire           clk,
  input  wire           rst_n,
  cfpg_in_if.sink       in_chan,
  cfpg_out_if.source    out_chan
);

  logic     s1_valid_r;
  in_item_t s1_item_r;
  logic     out_valid_r;
  pix_t     out_pix_r;
  pix_t     pix_nxt;
  logic     s2_ready;
  logic     s1_ready;

  assign s2_ready      = !out_valid_r || out_chan.ready;
  assign s1_ready      = !s1_valid_r || s2_ready;
  assign in_chan.ready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_chan.valid) begin
      s1_item_r <= '{pixel_x:   in_chan.pixel_x,
                     pixel_y:   in_chan.pixel_y,
                     hours:     in_chan.hours,
                     minutes:   in_chan.minutes,
                     colon_on:  in_chan.colon_on,
                     wifi_up:   in_chan.wifi_up,
                     bt_up:     in_chan.bt_up,
                     zigbee_up: in_chan.zigbee_up};
    end
  end

  cfpg_render u_render (
    .item        (s1_item_r),
    .pixel_value (pix_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      out_pix_r <= pix_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.pixel_value = out_pix_r;

endmodule

`default_nettype wire

// ===== src/cfpg_checker.sv =====
`default_nettype none

module cfpg_checker
  import cfpg_pkg::*;
(
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire pix_t pixel_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pixel_value == LIT_OFF) || (pixel_value == LIT_DOT) ||
                  (pixel_value == LIT_FULL))
    else $error("illegal pixel level");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("transfer did not reach the output");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind clock_face_pixel_generator_core cfpg_checker u_cfpg_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .pixel_value (out_chan.pixel_value)
);

`default_nettype wire
